@@ rtl/zcs_pkg.sv @@
// ----------------------------------------------------------------------------
// zcs_pkg
// Shared types and constants of the zero crossing snap block.
// ----------------------------------------------------------------------------
`default_nettype none

package zcs_pkg;

  localparam int unsigned TABLE_DEPTH = 4096;
  localparam int unsigned ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = ADDR_W + 1;
  localparam int unsigned POS_W       = 24;
  localparam int unsigned SAMPLE_W    = 16;
  localparam int unsigned WIN_W       = 12;
  localparam int unsigned CMD_W       = 2;

  localparam logic [WIN_W-1:0] WIN_RESET = 12'd221;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_PUSH  = 2'd1,
    CMD_QUERY = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_CHK_HI,
    ST_CHK_LO,
    ST_DONE
  } state_t;

  // result of the shared subtractor
  typedef struct packed {
    logic             lt;
    logic [POS_W-1:0] diff;
  } sub_res_t;

endpackage

`default_nettype wire

@@ rtl/zcs_if.sv @@
// ----------------------------------------------------------------------------
// zcs_if
// Valid/ready channels of the zero crossing snap block: commands in, results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface zcs_in_if;
  logic                                valid;
  logic                                ready;
  logic [zcs_pkg::CMD_W-1:0]           command;
  logic signed [zcs_pkg::SAMPLE_W-1:0] sample_value;
  logic [zcs_pkg::POS_W-1:0]           query_position;

  modport source (output valid, command, sample_value, query_position, input ready);
  modport sink   (input valid, command, sample_value, query_position, output ready);
endinterface

interface zcs_out_if;
  logic                      valid;
  logic                      ready;
  logic                      found;
  logic [zcs_pkg::POS_W-1:0] position;
  logic [zcs_pkg::CNT_W-1:0] crossing_count;
  logic                      overflow;

  modport source (output valid, found, position, crossing_count, overflow, input ready);
  modport sink   (input valid, found, position, crossing_count, overflow, output ready);
endinterface

`default_nettype wire

@@ rtl/zcs_ram.sv @@
// ----------------------------------------------------------------------------
// zcs_ram
// Generic simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module zcs_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

@@ rtl/zcs_sub.sv @@
// ----------------------------------------------------------------------------
// zcs_sub
// Shared subtract/compare unit used by every search and distance step.
// ----------------------------------------------------------------------------
`default_nettype none

module zcs_sub (
  input  wire logic [zcs_pkg::POS_W-1:0] a,
  input  wire logic [zcs_pkg::POS_W-1:0] b,
  output zcs_pkg::sub_res_t              res
);

  logic [zcs_pkg::POS_W:0] full;

  assign full     = {1'b0, a} - {1'b0, b};
  assign res.lt   = full[zcs_pkg::POS_W];
  assign res.diff = full[zcs_pkg::POS_W-1:0];

endmodule

`default_nettype wire

@@ rtl/zero_crossing_snap.sv @@
// ----------------------------------------------------------------------------
// zero_crossing_snap
// Records rising zero crossings of a sample stream and snaps query positions
// to the nearest recorded crossing within a configurable window.
// ----------------------------------------------------------------------------
// Every command gives exactly one result. Clear, push and the unused command
// code finish in the cycle of their transfer, so a stream of pushes runs at
// one sample per clock while the result side keeps up. A query with an empty
// table or a zero window also finishes at once. Any other query runs a binary
// search over the crossing table through its single registered read port and
// one shared subtractor: each probe reads the table in PROBE and compares in
// CMP, then CHK_HI and CHK_LO check the nearest crossings at or after and
// before the query, and DONE waits for the result register. No new command
// is taken while a query runs. The crossing table holds no reset: only
// entries below the current count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none

module zero_crossing_snap (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  zcs_in_if.sink                         in_ch,
  zcs_out_if.source                      out_ch,
  input  wire logic                      cfg_wr_en,
  input  wire logic [zcs_pkg::WIN_W-1:0] cfg_wr_data
);

  localparam int unsigned AW = zcs_pkg::ADDR_W;
  localparam int unsigned CW = zcs_pkg::CNT_W;
  localparam int unsigned PW = zcs_pkg::POS_W;
  localparam int unsigned WW = zcs_pkg::WIN_W;

  // sequencer
  zcs_pkg::state_t state_r, state_nxt;

  // search registers
  logic [CW-1:0] lo_r, lo_nxt;
  logic [CW-1:0] hi_r, hi_nxt;
  logic [CW-1:0] mid_r, mid_nxt;
  logic [PW-1:0] q_r, q_nxt;
  logic [WW:0]   best_r, best_nxt;
  logic          found_r, found_nxt;
  logic [PW-1:0] pos_r, pos_nxt;

  // stream state
  logic [CW-1:0] count_r, count_nxt;
  logic [PW-1:0] sidx_r, sidx_nxt;
  logic          have_prev_r, have_prev_nxt;
  logic          prev_nonpos_r, prev_nonpos_nxt;
  logic          dropped_r, dropped_nxt;
  logic [WW-1:0] win_r;

  // output register
  logic          out_valid_r;
  logic          out_found_r, out_found_nxt;
  logic [PW-1:0] out_pos_r, out_pos_nxt;
  logic [CW-1:0] out_count_r, out_count_nxt;
  logic          out_ovf_r, out_ovf_nxt;
  logic          load_out;

  // handshake
  logic out_free;
  logic accept;
  logic start_search;

  // table access
  logic          wr_en;
  logic [PW-1:0] rd_data;
  logic [AW-1:0] rd_addr;

  // shared subtractor
  logic [PW-1:0]     sub_a, sub_b;
  zcs_pkg::sub_res_t sub_res;

  // search helpers
  logic [CW:0]   mid_sum;
  logic [CW-1:0] mid;
  logic [CW-1:0] k_m1;
  logic          k_lt_cnt;
  logic          k_nz;
  logic          positive;
  logic          crossing;
  logic          table_full;

  // the result register frees up when empty or being taken this cycle
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == zcs_pkg::ST_IDLE) && out_free;
  assign accept       = in_ch.valid && in_ch.ready;
  assign start_search = accept && (in_ch.command == zcs_pkg::CMD_QUERY)
                        && (count_r != '0) && (win_r != '0);

  assign mid_sum  = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid      = mid_sum[CW:1];
  assign k_m1     = lo_r - CW'(1);
  assign k_lt_cnt = lo_r < count_r;
  assign k_nz     = lo_r != '0;

  // strictly greater than zero in two's complement
  assign positive   = (in_ch.sample_value != '0) && !in_ch.sample_value[zcs_pkg::SAMPLE_W-1];
  assign crossing   = have_prev_r && prev_nonpos_r && positive;
  assign table_full = count_r == CW'(zcs_pkg::TABLE_DEPTH);
  assign wr_en      = accept && (in_ch.command == zcs_pkg::CMD_PUSH) && crossing && !table_full;

  zcs_ram #(
    .WIDTH (PW),
    .DEPTH (zcs_pkg::TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (count_r[AW-1:0]),
    .wr_data (sidx_r),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  zcs_sub u_sub (
    .a   (sub_a),
    .b   (sub_b),
    .res (sub_res)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      zcs_pkg::ST_IDLE: begin
        if (start_search) begin
          state_nxt = zcs_pkg::ST_PROBE;
        end
      end
      zcs_pkg::ST_PROBE: begin
        if (lo_r < hi_r) begin
          state_nxt = zcs_pkg::ST_CMP;
        end else if (k_lt_cnt) begin
          state_nxt = zcs_pkg::ST_CHK_HI;
        end else if (k_nz) begin
          state_nxt = zcs_pkg::ST_CHK_LO;
        end else begin
          state_nxt = zcs_pkg::ST_DONE;
        end
      end
      zcs_pkg::ST_CMP: begin
        state_nxt = zcs_pkg::ST_PROBE;
      end
      zcs_pkg::ST_CHK_HI: begin
        state_nxt = k_nz ? zcs_pkg::ST_CHK_LO : zcs_pkg::ST_DONE;
      end
      zcs_pkg::ST_CHK_LO: begin
        state_nxt = zcs_pkg::ST_DONE;
      end
      zcs_pkg::ST_DONE: begin
        if (out_free) begin
          state_nxt = zcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = zcs_pkg::ST_IDLE;
      end
    endcase
  end

  // search datapath: table address, subtractor operands, search registers
  always_comb begin
    rd_addr   = mid[AW-1:0];
    sub_a     = rd_data;
    sub_b     = q_r;
    lo_nxt    = lo_r;
    hi_nxt    = hi_r;
    mid_nxt   = mid_r;
    q_nxt     = q_r;
    best_nxt  = best_r;
    found_nxt = found_r;
    pos_nxt   = pos_r;
    unique case (state_r)
      zcs_pkg::ST_IDLE: begin
        if (start_search) begin
          lo_nxt    = '0;
          hi_nxt    = count_r;
          q_nxt     = in_ch.query_position;
          best_nxt  = {1'b0, win_r} + (WW+1)'(1);
          found_nxt = 1'b0;
          pos_nxt   = '0;
        end
      end
      zcs_pkg::ST_PROBE: begin
        // read the probe, or the first candidate once the search has closed
        if (lo_r < hi_r) begin
          rd_addr = mid[AW-1:0];
          mid_nxt = mid;
        end else if (k_lt_cnt) begin
          rd_addr = lo_r[AW-1:0];
        end else begin
          rd_addr = k_m1[AW-1:0];
        end
      end
      zcs_pkg::ST_CMP: begin
        // table entry below the query moves the lower bound past the probe
        if (sub_res.lt) begin
          lo_nxt = mid_r + CW'(1);
        end else begin
          hi_nxt = mid_r;
        end
      end
      zcs_pkg::ST_CHK_HI: begin
        // crossing at or after the query, distance c - q
        rd_addr = k_m1[AW-1:0];
        if (sub_res.diff <= PW'(win_r)) begin
          found_nxt = 1'b1;
          pos_nxt   = rd_data;
          best_nxt  = sub_res.diff[WW:0];
        end
      end
      zcs_pkg::ST_CHK_LO: begin
        // left neighbor, distance q - c; ties stay with the later crossing
        sub_a = q_r;
        sub_b = rd_data;
        if ((sub_res.diff <= PW'(win_r)) && (sub_res.diff < PW'(best_r))) begin
          found_nxt = 1'b1;
          pos_nxt   = rd_data;
        end
      end
      zcs_pkg::ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // stream state, the result of commands that finish on transfer, and the query result
  always_comb begin
    count_nxt       = count_r;
    sidx_nxt        = sidx_r;
    have_prev_nxt   = have_prev_r;
    prev_nonpos_nxt = prev_nonpos_r;
    dropped_nxt     = dropped_r;
    out_found_nxt   = 1'b0;
    out_pos_nxt     = '0;
    if (accept) begin
      unique case (in_ch.command)
        zcs_pkg::CMD_CLEAR: begin
          count_nxt       = '0;
          sidx_nxt        = '0;
          have_prev_nxt   = 1'b0;
          prev_nonpos_nxt = 1'b0;
          dropped_nxt     = 1'b0;
        end
        zcs_pkg::CMD_PUSH: begin
          if (crossing) begin
            if (!table_full) begin
              count_nxt     = count_r + CW'(1);
              out_found_nxt = 1'b1;
              out_pos_nxt   = sidx_r;
            end else begin
              dropped_nxt = 1'b1;
            end
          end
          prev_nonpos_nxt = !positive;
          have_prev_nxt   = 1'b1;
          // index saturates so the table stays sorted
          if (sidx_r != '1) begin
            sidx_nxt = sidx_r + PW'(1);
          end
        end
        default: begin
        end
      endcase
    end
    out_count_nxt = count_nxt;
    out_ovf_nxt   = dropped_nxt;
    if (state_r == zcs_pkg::ST_DONE) begin
      out_found_nxt = found_r;
      out_pos_nxt   = pos_r;
    end
  end

  assign load_out = (accept && !start_search) || ((state_r == zcs_pkg::ST_DONE) && out_free);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= zcs_pkg::ST_IDLE;
      count_r       <= '0;
      sidx_r        <= '0;
      have_prev_r   <= 1'b0;
      prev_nonpos_r <= 1'b0;
      dropped_r     <= 1'b0;
      win_r         <= zcs_pkg::WIN_RESET;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      count_r       <= count_nxt;
      sidx_r        <= sidx_nxt;
      have_prev_r   <= have_prev_nxt;
      prev_nonpos_r <= prev_nonpos_nxt;
      dropped_r     <= dropped_nxt;
      if (cfg_wr_en) begin
        win_r <= cfg_wr_data;
      end
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    lo_r    <= lo_nxt;
    hi_r    <= hi_nxt;
    mid_r   <= mid_nxt;
    q_r     <= q_nxt;
    best_r  <= best_nxt;
    found_r <= found_nxt;
    pos_r   <= pos_nxt;
    if (load_out) begin
      out_found_r <= out_found_nxt;
      out_pos_r   <= out_pos_nxt;
      out_count_r <= out_count_nxt;
      out_ovf_r   <= out_ovf_nxt;
    end
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.found          = out_found_r;
  assign out_ch.position       = out_pos_r;
  assign out_ch.crossing_count = out_count_r;
  assign out_ch.overflow       = out_ovf_r;

endmodule

`default_nettype wire
